>>> hw/rtl/bpt_pkg.sv
`timescale 1ns / 1ps
// shared constants and widths for the boarders point transform
// no dependencies; used by the interfaces, bpt_round and the top level

package bpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int XW = 32;                       // coordinate and sum width
	localparam int RNDW = 16;                     // random word width
	localparam int NW = XW - FRAC_BITS + 1;       // rounded integer part, signed
	localparam int OW = FRAC_BITS + 1;            // offset, signed
	localparam int MW = FRAC_BITS;                // offset magnitude
	localparam int TW = XW + 4;                   // bracket in quarter-lsb units
	localparam int LW = FRAC_BITS + 2;            // low part of the bracket
	localparam int HW = TW - LW;                  // high part of the bracket
	localparam int QW = FRAC_BITS + 1;            // ratio quotient
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS = QW;
	localparam int STEPS_PER = (DIV_STEPS + DIV_STAGES - 1) / DIV_STAGES;
	localparam int PH = XW + HW;                  // weight * high part
	localparam int PL = XW + LW + 1;              // weight * low part
	localparam int CW = ((PH > PL) ? PH : PL) + 1;

	// random words at or above this take the plain branch
	localparam logic [RNDW-1:0] PLAIN_MIN = RNDW'(3) << (RNDW - 2);
	localparam logic signed [XW-1:0] WEIGHT_RESET = XW'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

endpackage

>>> hw/rtl/bpt_ifs.sv
`timescale 1ns / 1ps
// valid/ready channels for the boarders point transform: point in, sums out
// depends on bpt_pkg for field widths

interface bpt_in_if;
	logic valid;
	logic ready;
	logic signed [bpt_pkg::XW-1:0] in_x;
	logic signed [bpt_pkg::XW-1:0] in_y;
	logic [bpt_pkg::RNDW-1:0] random_word;
	logic signed [bpt_pkg::XW-1:0] acc_x;
	logic signed [bpt_pkg::XW-1:0] acc_y;

	modport source (output valid, output in_x, output in_y, output random_word,
		output acc_x, output acc_y, input ready);
	modport sink (input valid, input in_x, input in_y, input random_word,
		input acc_x, input acc_y, output ready);
endinterface

interface bpt_out_if;
	logic valid;
	logic ready;
	logic signed [bpt_pkg::XW-1:0] sum_x;
	logic signed [bpt_pkg::XW-1:0] sum_y;

	modport source (output valid, output sum_x, output sum_y, input ready);
	modport sink (input valid, input sum_x, input sum_y, output ready);
endinterface

>>> hw/rtl/boarders_point_transform.sv
`timescale 1ns / 1ps
// boarders flame variation, top level: ten-stage pipeline with ratio divider
// depends on bpt_pkg, bpt_ifs (bpt_in_if, bpt_out_if) and bpt_round

// Accepts one point per clock unless stalled. Stage 1 rounds both coordinates,
// stage 2 picks the major axis and forms the brackets, stages 3 to 6 run the
// 17-step offset-ratio division at up to five steps a stage, stage 7 adds the
// ratio, stage 8 multiplies the weight by the two halves of each bracket,
// stage 9 recombines and stage 10 adds and saturates. The whole pipe stalls
// together only while the last stage holds a result that is not taken, so a
// bubble costs nothing when the sink is ready. The user must write the weight
// only while the pipe is empty; the block does not check it. It resets to 1.0.

module boarders_point_transform (
	input  logic clk,
	input  logic arst_n,
	input  logic weight_we,
	input  logic [bpt_pkg::XW-1:0] weight_wdata,
	bpt_in_if.sink point,
	bpt_out_if.source result
);

	localparam int STAGES = 6 + bpt_pkg::DIV_STAGES;
	localparam logic signed [bpt_pkg::TW-1:0] ONE_T = bpt_pkg::TW'(1) << bpt_pkg::FRAC_BITS;
	localparam logic [bpt_pkg::QW-1:0] ONE_Q = bpt_pkg::QW'(1) << bpt_pkg::FRAC_BITS;
	localparam logic signed [bpt_pkg::CW-1:0] SAT_HI =
		bpt_pkg::CW'({1'b0, {(bpt_pkg::XW-1){1'b1}}});
	localparam logic signed [bpt_pkg::CW-1:0] SAT_LO = -SAT_HI - bpt_pkg::CW'(1);

	typedef struct packed {
		logic signed [bpt_pkg::TW-1:0] tx;
		logic signed [bpt_pkg::TW-1:0] ty;
		logic signed [bpt_pkg::XW-1:0] acc_x;
		logic signed [bpt_pkg::XW-1:0] acc_y;
		logic neg;
		logic x_major;
		logic use_ratio;
	} side_t;

	typedef struct packed {
		logic [bpt_pkg::MW-1:0] rem;
		logic [bpt_pkg::QW-1:0] quo;
		logic [bpt_pkg::QW-1:0] nbits;
		logic [bpt_pkg::MW-1:0] den;
	} div_t;

	function automatic logic signed [bpt_pkg::XW-1:0] sat(input logic signed [bpt_pkg::CW-1:0] v);
		logic signed [bpt_pkg::CW-1:0] c;
		c = v;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end
		return c[bpt_pkg::XW-1:0];
	endfunction

	logic en;
	logic [STAGES:1] vld_q;
	logic signed [bpt_pkg::XW-1:0] weight_q;

	// stage 1
	logic signed [bpt_pkg::NW-1:0] nx, ny, nx_s1, ny_s1;
	logic signed [bpt_pkg::OW-1:0] ox, oy, ox_s1, oy_s1;
	logic border_s1;
	logic signed [bpt_pkg::XW-1:0] acc_x_s1, acc_y_s1;

	// stage 2
	side_t side_n, side_s2;
	div_t div_n, div_s2;

	// divider stages, s3 onward
	side_t side_sd [bpt_pkg::DIV_STAGES];
	div_t div_sd [bpt_pkg::DIV_STAGES];

	// stages 7 to 10
	logic signed [bpt_pkg::TW-1:0] tx_s7, ty_s7;
	logic signed [bpt_pkg::XW-1:0] acc_x_s7, acc_y_s7, acc_x_s8, acc_y_s8, acc_x_s9, acc_y_s9;
	logic signed [bpt_pkg::PH-1:0] whx_s8, why_s8;
	logic signed [bpt_pkg::PL-1:0] wlx_s8, wly_s8;
	logic signed [bpt_pkg::CW-1:0] cx_s9, cy_s9;
	logic signed [bpt_pkg::XW-1:0] sum_x_s10, sum_y_s10;

	assign en = !vld_q[STAGES] || result.ready;
	assign point.ready = en;
	assign result.valid = vld_q[STAGES];
	assign result.sum_x = sum_x_s10;
	assign result.sum_y = sum_y_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			weight_q <= bpt_pkg::WEIGHT_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[STAGES-1:1], point.valid};
			end
			if (weight_we) begin
				weight_q <= weight_wdata;
			end
		end
	end

	bpt_round u_round_x (.coord(point.in_x), .n(nx), .o(ox));
	bpt_round u_round_y (.coord(point.in_y), .n(ny), .o(oy));

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= nx;
			ny_s1 <= ny;
			ox_s1 <= ox;
			oy_s1 <= oy;
			border_s1 <= point.random_word < bpt_pkg::PLAIN_MIN;
			acc_x_s1 <= point.acc_x;
			acc_y_s1 <= point.acc_y;
		end
	end

	// major axis, brackets, push toward the border, divider setup
	always_comb begin
		logic [bpt_pkg::MW-1:0] aox, aoy, num;
		logic signed [bpt_pkg::TW-1:0] tbx, tby;
		aox = ox_s1[bpt_pkg::OW-1] ? bpt_pkg::MW'(-ox_s1) : bpt_pkg::MW'(ox_s1);
		aoy = oy_s1[bpt_pkg::OW-1] ? bpt_pkg::MW'(-oy_s1) : bpt_pkg::MW'(oy_s1);
		tbx = {{(bpt_pkg::TW-bpt_pkg::NW-bpt_pkg::LW){nx_s1[bpt_pkg::NW-1]}}, nx_s1,
			{bpt_pkg::LW{1'b0}}}
			+ {{(bpt_pkg::TW-bpt_pkg::OW-1){ox_s1[bpt_pkg::OW-1]}}, ox_s1, 1'b0};
		tby = {{(bpt_pkg::TW-bpt_pkg::NW-bpt_pkg::LW){ny_s1[bpt_pkg::NW-1]}}, ny_s1,
			{bpt_pkg::LW{1'b0}}}
			+ {{(bpt_pkg::TW-bpt_pkg::OW-1){oy_s1[bpt_pkg::OW-1]}}, oy_s1, 1'b0};
		side_n.x_major = aox >= aoy;
		side_n.tx = tbx;
		side_n.ty = tby;
		if (border_s1) begin
			if (side_n.x_major) begin
				side_n.tx = tbx + (ox_s1[bpt_pkg::OW-1] ? -ONE_T : ONE_T);
			end else begin
				side_n.ty = tby + (oy_s1[bpt_pkg::OW-1] ? -ONE_T : ONE_T);
			end
		end
		num = side_n.x_major ? aoy : aox;
		div_n.den = side_n.x_major ? aox : aoy;
		side_n.neg = side_n.x_major ? oy_s1[bpt_pkg::OW-1] : ox_s1[bpt_pkg::OW-1];
		// both offsets zero gives no ratio
		side_n.use_ratio = border_s1 && (div_n.den != '0);
		side_n.acc_x = acc_x_s1;
		side_n.acc_y = acc_y_s1;
		div_n.rem = num >> 1;
		div_n.nbits = {num[0], {bpt_pkg::FRAC_BITS{1'b0}}};
		div_n.quo = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_n;
			div_s2 <= div_n;
		end
	end

	// restoring division of minor * 2^frac by major magnitude
	for (genvar d = 0; d < bpt_pkg::DIV_STAGES; d++) begin : g_div
		div_t prev_div, nxt_div;
		side_t prev_side;

		if (d == 0) begin : g_first
			assign prev_div = div_s2;
			assign prev_side = side_s2;
		end else begin : g_rest
			assign prev_div = div_sd[d-1];
			assign prev_side = side_sd[d-1];
		end

		always_comb begin
			logic [bpt_pkg::MW:0] trial;
			div_t w;
			w = prev_div;
			trial = '0;
			for (int k = 0; k < bpt_pkg::STEPS_PER; k++) begin
				if (d * bpt_pkg::STEPS_PER + k < bpt_pkg::DIV_STEPS) begin
					trial = {w.rem, w.nbits[bpt_pkg::QW-1]};
					w.nbits = w.nbits << 1;
					if (trial >= {1'b0, w.den}) begin
						w.rem = bpt_pkg::MW'(trial - {1'b0, w.den});
						w.quo = {w.quo[bpt_pkg::QW-2:0], 1'b1};
					end else begin
						w.rem = trial[bpt_pkg::MW-1:0];
						w.quo = {w.quo[bpt_pkg::QW-2:0], 1'b0};
					end
				end
			end
			nxt_div = w;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_sd[d] <= nxt_div;
				side_sd[d] <= prev_side;
			end
		end
	end

	// ratio onto the minor axis
	always_ff @(posedge clk) begin
		logic signed [bpt_pkg::TW-1:0] rt;
		side_t sl;
		sl = side_sd[bpt_pkg::DIV_STAGES-1];
		rt = '0;
		if (sl.use_ratio) begin
			rt = bpt_pkg::TW'(div_sd[bpt_pkg::DIV_STAGES-1].quo);
			if (sl.neg) begin
				rt = -rt;
			end
		end
		if (en) begin
			tx_s7 <= sl.x_major ? sl.tx : sl.tx + rt;
			ty_s7 <= sl.x_major ? sl.ty + rt : sl.ty;
			acc_x_s7 <= sl.acc_x;
			acc_y_s7 <= sl.acc_y;
		end
	end

	// weight times bracket split into a signed high and unsigned low half
	always_ff @(posedge clk) begin
		if (en) begin
			whx_s8 <= weight_q * $signed(tx_s7[bpt_pkg::TW-1:bpt_pkg::LW]);
			why_s8 <= weight_q * $signed(ty_s7[bpt_pkg::TW-1:bpt_pkg::LW]);
			wlx_s8 <= weight_q * $signed({1'b0, tx_s7[bpt_pkg::LW-1:0]});
			wly_s8 <= weight_q * $signed({1'b0, ty_s7[bpt_pkg::LW-1:0]});
			acc_x_s8 <= acc_x_s7;
			acc_y_s8 <= acc_y_s7;
		end
	end

	// floor of the full product back to frac units
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s9 <= bpt_pkg::CW'(whx_s8) + bpt_pkg::CW'(wlx_s8 >>> bpt_pkg::LW);
			cy_s9 <= bpt_pkg::CW'(why_s8) + bpt_pkg::CW'(wly_s8 >>> bpt_pkg::LW);
			acc_x_s9 <= acc_x_s8;
			acc_y_s9 <= acc_y_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_x_s10 <= sat(bpt_pkg::CW'(acc_x_s9) + cx_s9);
			sum_y_s10 <= sat(bpt_pkg::CW'(acc_y_s9) + cy_s9);
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_major_ge_minor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> (div_s2.rem <= div_s2.den))
		else $error("minor offset exceeds major offset");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2 + bpt_pkg::DIV_STAGES] && side_sd[bpt_pkg::DIV_STAGES-1].use_ratio
		|-> div_sd[bpt_pkg::DIV_STAGES-1].quo <= ONE_Q)
		else $error("offset ratio above one");

	a_weight_held: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(weight_we) |-> $stable(weight_q))
		else $error("weight changed without a write");

endmodule

>>> hw/rtl/bpt_round.sv
`timescale 1ns / 1ps
// round one fixed-point coordinate to the nearest integer, ties to even,
// and form the fractional offset; depends on bpt_pkg

module bpt_round (
	input  logic signed [bpt_pkg::XW-1:0] coord,
	output logic signed [bpt_pkg::NW-1:0] n,
	output logic signed [bpt_pkg::OW-1:0] o
);

	logic [bpt_pkg::XW:0] biased;
	logic [bpt_pkg::NW-1:0] n_floor;
	logic tie;

	always_comb begin
		biased = {coord[bpt_pkg::XW-1], coord} + (bpt_pkg::XW + 1)'(bpt_pkg::HALF);
		n_floor = biased[bpt_pkg::XW:bpt_pkg::FRAC_BITS];
		tie = (coord[bpt_pkg::FRAC_BITS-1:0] == bpt_pkg::HALF) && n_floor[0];
		n = tie ? n_floor - bpt_pkg::NW'(1) : n_floor;
		// only the low bits matter, the offset always fits
		o = coord[bpt_pkg::FRAC_BITS:0] - {n[0], {bpt_pkg::FRAC_BITS{1'b0}}};
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for boarders_point_transform: directed and random points
// depends on bpt_pkg and the bpt_in_if / bpt_out_if channels from hw/rtl

module tb;

	typedef struct packed {
		logic signed [bpt_pkg::XW-1:0] in_x;
		logic signed [bpt_pkg::XW-1:0] in_y;
		logic [bpt_pkg::RNDW-1:0] random_word;
		logic signed [bpt_pkg::XW-1:0] acc_x;
		logic signed [bpt_pkg::XW-1:0] acc_y;
	} point_t;

	typedef struct packed {
		logic signed [bpt_pkg::XW-1:0] sum_x;
		logic signed [bpt_pkg::XW-1:0] sum_y;
	} sums_t;

	localparam longint ONE = longint'(1) <<< bpt_pkg::FRAC_BITS;
	localparam longint HALF_ONE = ONE >>> 1;
	localparam longint FRAC_MASK = ONE - 1;
	localparam int QUARTER_SHIFT = bpt_pkg::FRAC_BITS + 2;
	localparam longint SAT_MAX = 64'sh7FFFFFFF;
	localparam longint SAT_MIN = -64'sh80000000;
	localparam int SETTLE_CYCLES = 14;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int NUM_PHASES = 9;
	localparam int PHASE_ITEMS = 55;

	// predicts the pair of sums for each accepted point and checks the outputs
	class border_sum_checker;
		sums_t sums_due[$];
		longint weight;
		int errors;
		int points_seen;
		int sums_checked;

		function new();
			weight = longint'(bpt_pkg::WEIGHT_RESET);
			errors = 0;
			points_seen = 0;
			sums_checked = 0;
		endfunction

		function int pending();
			return sums_due.size();
		endfunction

		function longint round_to_even(longint v);
			longint n;
			n = (v + HALF_ONE) >>> bpt_pkg::FRAC_BITS;
			// exact half with an odd candidate goes down to the even one
			if ((v & FRAC_MASK) == HALF_ONE && n[0])
				n = n - 1;
			return n;
		endfunction

		// quarter of num/|den| in quarter-lsb units, truncated toward zero
		function longint quarter_ratio(longint num, longint den);
			longint an, ad, q;
			an = (num < 0) ? -num : num;
			ad = (den < 0) ? -den : den;
			if (ad == 0)
				return 0;
			q = (an <<< bpt_pkg::FRAC_BITS) / ad;
			return (num < 0) ? -q : q;
		endfunction

		function logic signed [bpt_pkg::XW-1:0] scale_and_add(longint acc, longint t4);
			longint h, l, c, s;
			h = t4 >>> QUARTER_SHIFT;
			l = t4 - (h <<< QUARTER_SHIFT);
			c = weight * h + ((weight * l) >>> QUARTER_SHIFT);
			s = acc + c;
			if (s > SAT_MAX)
				s = SAT_MAX;
			else if (s < SAT_MIN)
				s = SAT_MIN;
			return s[bpt_pkg::XW-1:0];
		endfunction

		function void note_request(point_t p);
			longint x, y, nx, ny, ox, oy, tx, ty, aox, aoy;
			sums_t e;
			x = p.in_x;
			y = p.in_y;
			nx = round_to_even(x);
			ny = round_to_even(y);
			ox = x - (nx <<< bpt_pkg::FRAC_BITS);
			oy = y - (ny <<< bpt_pkg::FRAC_BITS);
			tx = 2 * ox + (nx <<< QUARTER_SHIFT);
			ty = 2 * oy + (ny <<< QUARTER_SHIFT);
			aox = (ox < 0) ? -ox : ox;
			aoy = (oy < 0) ? -oy : oy;
			if (p.random_word < bpt_pkg::PLAIN_MIN) begin
				// border branch: x wins ties on the offset magnitude
				if (aox >= aoy) begin
					tx += (ox >= 0) ? ONE : -ONE;
					ty += quarter_ratio(oy, ox);
				end else begin
					ty += (oy >= 0) ? ONE : -ONE;
					tx += quarter_ratio(ox, oy);
				end
			end
			e.sum_x = scale_and_add(longint'(p.acc_x), tx);
			e.sum_y = scale_and_add(longint'(p.acc_y), ty);
			sums_due.push_back(e);
			points_seen++;
		endfunction

		function void check_result(logic signed [bpt_pkg::XW-1:0] sx,
				logic signed [bpt_pkg::XW-1:0] sy);
			sums_t e;
			if (sums_due.size() == 0) begin
				$display("%0t unexpected result: expected none actual sum_x %h sum_y %h",
					$time, sx, sy);
				errors++;
				return;
			end
			e = sums_due.pop_front();
			sums_checked++;
			if (sx !== e.sum_x) begin
				$display("%0t sum_x mismatch: expected %h actual %h", $time, e.sum_x, sx);
				errors++;
			end
			if (sy !== e.sum_y) begin
				$display("%0t sum_y mismatch: expected %h actual %h", $time, e.sum_y, sy);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic weight_we;
	logic [bpt_pkg::XW-1:0] weight_wdata;

	bpt_in_if point_ch();
	bpt_out_if result_ch();

	boarders_point_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.weight_we(weight_we),
		.weight_wdata(weight_wdata),
		.point(point_ch),
		.result(result_ch)
	);

	border_sum_checker sb = new();

	int idle_pct;
	int stall_pct;
	bit long_hold;
	int hold_left;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// request and result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.sum_x, result_ch.sum_y);
			if (point_ch.valid && point_ch.ready)
				sb.note_request('{point_ch.in_x, point_ch.in_y, point_ch.random_word,
					point_ch.acc_x, point_ch.acc_y});
		end
	end

	// receiver: random stalls, plus a long hold-off counted here on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (long_hold) begin
				hold_left = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (point_ch.valid && point_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t timeout: no handshake for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, sb.pending());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic point_t mk_point(logic [31:0] x, logic [31:0] y, logic [15:0] r,
			logic [31:0] ax, logic [31:0] ay);
		point_t p;
		p.in_x = x;
		p.in_y = y;
		p.random_word = r;
		p.acc_x = ax;
		p.acc_y = ay;
		return p;
	endfunction

	function automatic logic [31:0] rand_coord();
		int k;
		logic [31:0] v;
		k = int'($urandom_range(16)) - 8;
		case ($urandom_range(9))
			0, 1, 2: v = $urandom;
			3, 4, 5: v = (k <<< 16) + int'($urandom_range(65535));
			6: v = (($urandom_range(1) ? $urandom : k) << 16) | 32'h0000_8000;
			7: v = $urandom & 32'hFFFF_0000;
			8: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(131072)
				: 32'h8000_0000 + $urandom_range(131072);
			default: v = int'($urandom_range(8)) - 4;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(3))
			0: return $urandom_range(65535);
			1: return $urandom_range(49163, 49140);
			2: return $urandom_range(49151);
			default: return $urandom_range(65535, 49152);
		endcase
	endfunction

	function automatic logic [31:0] rand_acc();
		case ($urandom_range(4))
			0, 1: return $urandom;
			2: return 32'h7FFF_FFFF - $urandom_range(262144);
			3: return 32'h8000_0000 + $urandom_range(262144);
			default: return int'($urandom_range(131072)) - 65536;
		endcase
	endfunction

	task automatic send_point(input point_t p);
		point_ch.valid <= 1'b1;
		point_ch.in_x <= p.in_x;
		point_ch.in_y <= p.in_y;
		point_ch.random_word <= p.random_word;
		point_ch.acc_x <= p.acc_x;
		point_ch.acc_y <= p.acc_y;
		do @(posedge clk); while (!point_ch.ready);
	endtask

	task automatic sender_gap();
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		point_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_weight(input logic [bpt_pkg::XW-1:0] w);
		weight_we <= 1'b1;
		weight_wdata <= w;
		@(posedge clk);
		weight_we <= 1'b0;
		sb.weight = longint'($signed(w));
	endtask

	initial begin
		logic [31:0] weights [NUM_PHASES];
		arst_n = 1'b0;
		weight_we = 1'b0;
		weight_wdata = '0;
		point_ch.valid = 1'b0;
		point_ch.in_x = '0;
		point_ch.in_y = '0;
		point_ch.random_word = '0;
		point_ch.acc_x = '0;
		point_ch.acc_y = '0;
		result_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		quiet_cycles = 0;

		weights[0] = 32'h8000_0000;
		weights[1] = 32'h7FFF_FFFF;
		weights[2] = 32'h0000_0000;
		weights[3] = 32'h0000_0001;
		weights[4] = 32'hFFFF_0000;
		weights[5] = 32'h0000_8000;
		weights[6] = $urandom;
		weights[7] = int'($urandom_range(262144)) - 131072;
		weights[8] = bpt_pkg::WEIGHT_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points at the reset weight, no idling
		send_point(mk_point(32'h0000_0000, 32'h0000_0000, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'h0000_0000, 32'h0000_0000, 16'd65535, 32'h0, 32'h0));
		send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 16'd49151, 32'h0, 32'h0));
		send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 16'd49152, 32'h0, 32'h0));
		send_point(mk_point(32'h0000_8000, 32'h0001_8000, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'hFFFF_8000, 32'hFFFE_8000, 16'd65535, 32'h0, 32'h0));
		send_point(mk_point(32'h0002_8000, 32'hFFFD_8000, 16'd100, 32'h0, 32'h0));
		send_point(mk_point(32'h0001_4000, 32'hFFFC_C000, 16'd0, 32'h1234, 32'h5678));
		send_point(mk_point(32'h0001_0100, 32'h0002_7000, 16'd1, 32'h0, 32'h0));
		send_point(mk_point(32'hFFFF_F000, 32'hFFFE_0800, 16'd2, 32'hFFFF_0000, 32'h0));
		send_point(mk_point(32'h0005_0000, 32'h0000_3000, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'h7FFF_FFFF, 32'h7FFF_0000, 16'd65535,
			32'h7FFF_FFFF, 32'h7FFF_FFF0));
		send_point(mk_point(32'h8000_0000, 32'h8000_0001, 16'd0,
			32'h8000_0000, 32'h8000_0005));
		send_point(mk_point(32'h0000_0000, 32'h0000_0000, 16'd0,
			32'h7FFF_FFFF, 32'h8000_0000));
		send_point(mk_point(32'h0000_FFFF, 32'hFFFF_0001, 16'd49152, 32'h0, 32'h0));
		send_point(mk_point(32'h0000_0001, 32'hFFFF_FFFF, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'h1234_5678, 32'h9ABC_DEF0, 16'd49151,
			32'hA5A5_5A5A, 32'h5A5A_A5A5));
		send_point(mk_point(32'h7FFF_8000, 32'h8000_8000, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'h0003_C000, 32'h0000_0000, 16'd0, 32'h0, 32'h0));
		send_point(mk_point(32'h0000_0000, 32'hFFFF_4000, 16'd0, 32'h0, 32'h0));
		drain_results();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// weight changes only with the pipe empty and settled
			repeat (SETTLE_CYCLES) @(posedge clk);
			write_weight(weights[ph]);
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 84; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 84; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			// back-pressure: sink holds off while points keep coming
			if (ph == 0)
				long_hold = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 4 && i == PHASE_ITEMS / 2)
					drain_results();
				sender_gap();
				send_point(mk_point(rand_coord(), rand_coord(), rand_word(),
					rand_acc(), rand_acc()));
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d points (%0d sums checked) over %0d weight settings,",
			sb.points_seen, sb.sums_checked, NUM_PHASES + 1);
		$display("with sender gaps, sink stalls, a long sink hold-off and a mid-run drain");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (sb.pending() != 0)
				$display("%0t %0d expected results never arrived", $time, sb.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
